/* rtl/core/brqb_pkg.sv */
// brqb_pkg: shared widths, command codes and the result bundle of the byte ring queue
// used by brqb_ctrl and byte_ring_queue_burst; no dependencies
package brqb_pkg;

    // field widths of one request and one result
    localparam int CMD_W      = 2;
    localparam int CNT_W      = 4;
    localparam int DATA_W     = 64;
    localparam int FILL_W     = 8;
    localparam int CAP_W      = 8;
    localparam int CAP_LIM_W  = CAP_W + 1;
    localparam int BYTE_W     = 8;
    localparam int BYTE_IDX_W = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

    // finished result handed from the sequencer to the output register
    typedef struct packed {
        logic              done;
        logic              ok;
        logic [DATA_W-1:0] read_bytes;
        logic [FILL_W-1:0] fill_level;
    } brqb_res_t;

endpackage

/* rtl/core/byte_ring_queue_burst.sv */
// byte_ring_queue_burst: circular byte queue with all-or-nothing bursts
// depends on brqb_pkg, brqb_ram and brqb_ctrl
//
//  channel  | direction | tdata (low bit up)                         | tuser
//  s_       | in        | byte_count[3:0], write_bytes[67:4], pad    | command[1:0]
//  m_       | out       | ok[0], read_bytes[64:1], fill_level[72:65], | -
//           |           | present[73], pad                           |
//  cfg_     | in        | capacity[7:0]                              | -
//
//  write burst: write, finish; read burst: read, drain, finish; flush, empty or
//  refused: finish only; the single byte port of the memory moves one byte a cycle
//  no new request is taken until the result has moved into the output register
//  a stalled m_ side holds the result and then holds the sequencer in its last step
//  synchronous active-low reset empties the queue and sets capacity to 255
module byte_ring_queue_burst import brqb_pkg::*; #(
    parameter int BUFFER_DEPTH = 256,
    parameter int MAX_BURST    = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // byte_count, write_bytes
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // ok, read_bytes, fill_level, present
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // capacity
);

    localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [CAP_W-1:0]     capacity_reg;
    logic [CAP_LIM_W-1:0] cap_lim;
    logic                 cfg_wr;
    logic                 out_free;
    brqb_res_t            res;

    logic                 m_tvalid_reg;
    logic [DATA_W-1:0]    out_bytes_reg;
    logic [FILL_W-1:0]    out_fill_reg;
    logic                 out_ok_reg;
    logic                 out_present_reg;

    logic                 mem_en;
    logic                 mem_we;
    logic [PTR_W-1:0]     mem_addr;
    logic [BYTE_W-1:0]    mem_wdata;
    logic [BYTE_W-1:0]    mem_rdata;

    // capacity register, limited to the buffer depth
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_W'(255);
        end else if (cfg_wr) begin
            capacity_reg <= cfg_data;
        end
    end

    assign cap_lim = (CAP_LIM_W'(capacity_reg) > CAP_LIM_W'(BUFFER_DEPTH))
                   ? CAP_LIM_W'(BUFFER_DEPTH) : CAP_LIM_W'(capacity_reg);

    // sequencer with the shared pointer unit
    brqb_ctrl #(
        .MAX_BURST    (MAX_BURST),
        .PTR_W        (PTR_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cap_lim   (cap_lim),
        .cfg_clear (cfg_wr),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (s_tuser),
        .count     (s_tdata[CNT_W-1:0]),
        .wbytes    (s_tdata[CNT_W +: DATA_W]),
        .out_free  (out_free),
        .res       (res),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    // byte storage
    brqb_ram #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .ADDR_W       (PTR_W)
    ) u_ram (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // output register
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= res.done;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res.done) begin
            out_ok_reg      <= res.ok;
            out_bytes_reg   <= res.read_bytes;
            out_fill_reg    <= res.fill_level;
            out_present_reg <= (capacity_reg != '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_present_reg, out_fill_reg, out_bytes_reg, out_ok_reg};

    // a request blocks the input side for at least the following cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken on consecutive cycles");

    // fill level never exceeds the capacity in use
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res.done |-> (CAP_LIM_W'(res.fill_level) <= cap_lim))
        else $error("fill level above capacity");

    // a refused request returns no bytes
    a_refused_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[64:1] == '0))
        else $error("refused request returned data");

    // a finished result leaves the sequencer only through the output register
    a_result_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.done && out_free) |=> m_tvalid)
        else $error("finished result lost");

endmodule

/* rtl/core/brqb_ram.sv */
// brqb_ram: single-port byte memory with registered read data
// no package dependency; used by byte_ring_queue_burst
module brqb_ram #(
    parameter int BUFFER_DEPTH = 256,
    parameter int ADDR_W       = 8
) (
    input  logic              aclk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem [BUFFER_DEPTH];

    // one access a cycle, read data registered and out in the cycle after its address
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

/* rtl/core/brqb_ctrl.sv */
// brqb_ctrl: burst sequencer, pointers and fill count of the byte ring queue
// depends on brqb_pkg; drives the port of brqb_ram one byte per cycle
module brqb_ctrl import brqb_pkg::*; #(
    parameter int MAX_BURST    = 8,
    parameter int PTR_W        = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [CAP_LIM_W-1:0] cap_lim,
    input  logic                 cfg_clear,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [CNT_W-1:0]     count,
    input  logic [DATA_W-1:0]    wbytes,
    input  logic                 out_free,
    output brqb_res_t            res,
    output logic                 mem_en,
    output logic                 mem_we,
    output logic [PTR_W-1:0]     mem_addr,
    output logic [BYTE_W-1:0]    mem_wdata,
    input  logic [BYTE_W-1:0]    mem_rdata
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WRITE  = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]            state_reg,   state_next;
    logic [PTR_W-1:0]      rd_ptr_reg,  rd_ptr_next;
    logic [PTR_W-1:0]      wr_ptr_reg,  wr_ptr_next;
    logic [FILL_W-1:0]     held_reg,    held_next;
    logic [CNT_W-1:0]      left_reg,    left_next;
    logic [BYTE_IDX_W-1:0] idx_reg,     idx_next;
    logic [DATA_W-1:0]     data_reg,    data_next;
    logic [DATA_W-1:0]     rd_acc_reg,  rd_acc_next;
    logic                  ok_reg,      ok_next;
    logic                  cap_vld_reg, cap_vld_next;
    logic [BYTE_IDX_W-1:0] cap_idx_reg, cap_idx_next;

    logic [PTR_W-1:0]      ptr_cur;
    logic [PTR_W:0]        ptr_inc;
    logic [PTR_W-1:0]      ptr_bump;
    logic [CAP_LIM_W-1:0]  room;
    logic [CAP_LIM_W-1:0]  cnt_ext;
    logic                  burst_ok;
    logic                  accept;

    // shared pointer advance: one increment and wrap compare against capacity
    always_comb begin
        ptr_cur  = (state_reg == ST_WRITE) ? wr_ptr_reg : rd_ptr_reg;
        ptr_inc  = {1'b0, ptr_cur} + {{PTR_W{1'b0}}, 1'b1};
        ptr_bump = (CAP_LIM_W'(ptr_inc) >= cap_lim) ? '0 : ptr_inc[PTR_W-1:0];
    end

    // admission checks for a new request
    assign room      = cap_lim - CAP_LIM_W'(held_reg);
    assign cnt_ext   = CAP_LIM_W'(count);
    assign burst_ok  = (count <= CNT_W'(MAX_BURST));
    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;

    // memory port follows the active pointer
    assign mem_en    = (state_reg == ST_WRITE) || (state_reg == ST_READ);
    assign mem_we    = (state_reg == ST_WRITE);
    assign mem_addr  = ptr_cur;
    assign mem_wdata = data_reg[BYTE_W-1:0];

    // result bundle
    assign res.done       = (state_reg == ST_FINISH);
    assign res.ok         = ok_reg;
    assign res.read_bytes = rd_acc_reg;
    assign res.fill_level = held_reg;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        held_next    = held_reg;
        left_next    = left_reg;
        idx_next     = idx_reg;
        data_next    = data_reg;
        rd_acc_next  = rd_acc_reg;
        ok_next      = ok_reg;
        cap_vld_next = (state_reg == ST_READ);
        cap_idx_next = idx_reg;

        // read data lands in the cycle after its address
        if (cap_vld_reg) begin
            rd_acc_next[{cap_idx_reg, 3'b000} +: BYTE_W] = mem_rdata;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    rd_acc_next = '0;
                    data_next   = wbytes;
                    left_next   = count;
                    idx_next    = '0;
                    ok_next     = 1'b0;
                    state_next  = ST_FINISH;
                    unique case (cmd)
                        CMD_WRITE: begin
                            if (burst_ok && (cnt_ext <= room)) begin
                                ok_next   = 1'b1;
                                held_next = held_reg + FILL_W'(count);
                                if (count != '0) begin
                                    state_next = ST_WRITE;
                                end
                            end
                        end
                        CMD_READ: begin
                            if (burst_ok && (cnt_ext <= CAP_LIM_W'(held_reg))) begin
                                ok_next   = 1'b1;
                                held_next = held_reg - FILL_W'(count);
                                if (count != '0) begin
                                    state_next = ST_READ;
                                end
                            end
                        end
                        CMD_FLUSH: begin
                            ok_next     = 1'b1;
                            held_next   = '0;
                            rd_ptr_next = '0;
                            wr_ptr_next = '0;
                        end
                        default: begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_WRITE: begin
                wr_ptr_next = ptr_bump;
                data_next   = data_reg >> BYTE_W;
                left_next   = left_reg - 1'b1;
                if (left_reg == CNT_W'(1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ: begin
                rd_ptr_next = ptr_bump;
                idx_next    = idx_reg + 1'b1;
                left_next   = left_reg - 1'b1;
                if (left_reg == CNT_W'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // capacity write empties the queue
        if (cfg_clear) begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            held_next   = '0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            held_reg    <= '0;
            cap_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            held_reg    <= held_next;
            cap_vld_reg <= cap_vld_next;
        end
    end

    // burst payload
    always_ff @(posedge aclk) begin
        left_reg    <= left_next;
        idx_reg     <= idx_next;
        data_reg    <= data_next;
        rd_acc_reg  <= rd_acc_next;
        ok_reg      <= ok_next;
        cap_idx_reg <= cap_idx_next;
    end

endmodule

/* tb/tb_byte_ring_queue_burst.sv */
// tb_byte_ring_queue_burst: self-checking bench for the circular byte queue with burst requests
// depends on brqb_pkg and byte_ring_queue_burst; predicts every reply and compares it field by field
module tb_byte_ring_queue_burst import brqb_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int BURST_LIMIT      = 8;
    localparam int SETTLE_CYCLES    = 16;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int PHASE_COUNT      = 12;
    localparam int HI_ITEMS         = 66;
    localparam int LO_ITEMS         = 44;
    localparam int TIMEOUT_NS       = 3_000_000;

    // one burst request as offered on the s_ side
    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] bytes;
    } burst_t;

    // one reply as seen on the m_ side
    typedef struct {
        logic              ok;
        logic [DATA_W-1:0] read_bytes;
        logic [FILL_W-1:0] fill_level;
        logic              present;
    } reply_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    logic [79:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    byte_ring_queue_burst dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // queue shadow: byte ring, pointers, fill and capacity
    logic [BYTE_W-1:0] ring_bytes [256];
    logic [CAP_W-1:0]  shadow_cap  = 8'd255;
    logic [CAP_W-1:0]  shadow_rd   = '0;
    logic [CAP_W-1:0]  shadow_wr   = '0;
    logic [FILL_W-1:0] shadow_fill = '0;

    burst_t burst_queue[$];
    reply_t awaited_replies[$];

    int requests_queued  = 0;
    int requests_taken   = 0;
    int mismatch_count   = 0;
    int replies_checked  = 0;
    int replies_ok       = 0;
    int replies_refused  = 0;
    int peak_fill        = 0;
    int settings_used    = 0;
    int send_gap_max     = 0;
    int recv_stall_max   = 0;
    int long_hold_reqs   = 0;
    int long_hold_seen   = 0;
    int gap_left         = 0;
    int stall_left       = 0;
    bit in_taken         = 1'b0;
    bit out_taken        = 1'b0;

    // pointer step with wrap at the capacity in use
    function automatic logic [CAP_W-1:0] ring_advance(logic [CAP_W-1:0] ptr);
        int nxt;
        nxt = int'(ptr) + 1;
        return (nxt >= int'(shadow_cap)) ? '0 : CAP_W'(nxt);
    endfunction

    // apply one burst request to the shadow and return the reply it should give
    function automatic reply_t predict_burst(logic [CMD_W-1:0] cmd, logic [CNT_W-1:0] cnt,
                                             logic [DATA_W-1:0] src);
        reply_t r;
        int n;
        r = '{ok: 1'b0, read_bytes: '0, fill_level: '0, present: 1'b0};
        n = int'(cnt);
        unique case (cmd)
            CMD_WRITE: begin
                if (n <= BURST_LIMIT && n <= int'(shadow_cap) - int'(shadow_fill)) begin
                    for (int i = 0; i < n; i++) begin
                        ring_bytes[shadow_wr] = src[8*i +: 8];
                        shadow_wr = ring_advance(shadow_wr);
                    end
                    shadow_fill = shadow_fill + FILL_W'(n);
                    r.ok = 1'b1;
                end
            end
            CMD_READ: begin
                if (n <= BURST_LIMIT && n <= int'(shadow_fill)) begin
                    for (int i = 0; i < n; i++) begin
                        r.read_bytes[8*i +: 8] = ring_bytes[shadow_rd];
                        shadow_rd = ring_advance(shadow_rd);
                    end
                    shadow_fill = shadow_fill - FILL_W'(n);
                    r.ok = 1'b1;
                end
            end
            CMD_FLUSH: begin
                shadow_rd   = '0;
                shadow_wr   = '0;
                shadow_fill = '0;
                r.ok        = 1'b1;
            end
            default: ;
        endcase
        r.fill_level = shadow_fill;
        r.present    = (shadow_cap != '0);
        return r;
    endfunction

    // one line per mismatch, counted
    task automatic report_mismatch(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        mismatch_count++;
        $display("[%0t] mismatch on reply %0d: %s got %h expected %h",
                 $time, replies_checked, field, got, want);
    endtask

    // request capture: predict the reply for every request the block takes
    always @(posedge aclk) begin : request_capture
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken) begin
            awaited_replies.push_back(predict_burst(s_tuser, s_tdata[3:0], s_tdata[67:4]));
            requests_taken++;
        end
    end

    // request driver: offer queued bursts with a random gap after each one
    always @(negedge aclk) begin : request_driver
        burst_t nxt;
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (in_taken)
                gap_left = $urandom_range(0, send_gap_max);
            if (gap_left == 0 && burst_queue.size() > 0) begin
                nxt = burst_queue.pop_front();
                s_tuser  <= nxt.cmd;
                s_tdata  <= {4'b0000, nxt.bytes, nxt.count};
                s_tvalid <= 1'b1;
            end else begin
                if (gap_left > 0)
                    gap_left--;
                s_tvalid <= 1'b0;
            end
        end
    end

    // reply checker: compare each accepted reply with the oldest prediction
    always @(posedge aclk) begin : reply_checker
        reply_t want;
        reply_t got;
        out_taken = aresetn && m_tvalid && m_tready;
        if (out_taken) begin
            got.ok         = m_tdata[0];
            got.read_bytes = m_tdata[64:1];
            got.fill_level = m_tdata[72:65];
            got.present    = m_tdata[73];
            if (awaited_replies.size() == 0) begin
                report_mismatch("unexpected reply", m_tdata[64:1], '0);
            end else begin
                want = awaited_replies.pop_front();
                if (got.ok !== want.ok)
                    report_mismatch("ok", got.ok, want.ok);
                if (got.read_bytes !== want.read_bytes)
                    report_mismatch("read_bytes", got.read_bytes, want.read_bytes);
                if (got.fill_level !== want.fill_level)
                    report_mismatch("fill_level", got.fill_level, want.fill_level);
                if (got.present !== want.present)
                    report_mismatch("present", got.present, want.present);
                if (want.ok)
                    replies_ok++;
                else
                    replies_refused++;
                if (int'(want.fill_level) > peak_fill)
                    peak_fill = int'(want.fill_level);
            end
            replies_checked++;
        end
    end

    // reply pacing: random stall after each reply, or a long hold when asked
    always @(negedge aclk) begin : reply_pacing
        if (out_taken)
            stall_left = $urandom_range(0, recv_stall_max);
        if (long_hold_reqs != long_hold_seen) begin
            long_hold_seen = long_hold_reqs;
            stall_left     = LONG_HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic queue_burst(logic [CMD_W-1:0] cmd, logic [CNT_W-1:0] cnt,
                               logic [DATA_W-1:0] bytes);
        burst_queue.push_back('{cmd: cmd, count: cnt, bytes: bytes});
        requests_queued++;
    endtask

    // random request: mostly writes and reads, a few flushes, unused commands and long bursts
    task automatic queue_random_burst(int write_pct);
        int pick;
        logic [CNT_W-1:0] cnt;
        logic [DATA_W-1:0] bytes;
        pick  = $urandom_range(0, 99);
        cnt   = ($urandom_range(0, 19) == 0) ? CNT_W'($urandom_range(9, 15))
                                              : CNT_W'($urandom_range(0, BURST_LIMIT));
        bytes = {$urandom, $urandom};
        if (pick < 3)
            queue_burst(CMD_FLUSH, cnt, bytes);
        else if (pick < 6)
            queue_burst(CMD_UNUSED, cnt, bytes);
        else if (pick < 6 + write_pct)
            queue_burst(CMD_WRITE, cnt, bytes);
        else
            queue_burst(CMD_READ, cnt, bytes);
    endtask

    // wait until every request is taken and every reply checked, then let the block settle
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (burst_queue.size() != 0 || requests_taken != requests_queued
               || awaited_replies.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // capacity write; only called while the queue is idle
    task automatic write_capacity(logic [CAP_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        shadow_cap  = value;
        shadow_rd   = '0;
        shadow_wr   = '0;
        shadow_fill = '0;
        settings_used++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial begin : stimulus
        logic [CAP_W-1:0] phase_caps [PHASE_COUNT];
        int write_hi;
        phase_caps = '{8'd255, 8'd2, 8'd7, 8'd16, 8'd0, 8'd1,
                       8'd255, 8'd0, 8'd100, 8'd3, 8'd0, 8'd255};
        phase_caps[4]  = CAP_W'($urandom_range(1, 254));
        phase_caps[10] = CAP_W'($urandom_range(1, 254));

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset capacity, limits of count and data, refusals, unused command
        send_gap_max   = 2;
        recv_stall_max = 2;
        queue_burst(CMD_WRITE, 4'd0, '1);
        queue_burst(CMD_WRITE, 4'd8, '1);
        queue_burst(CMD_WRITE, 4'd8, '0);
        queue_burst(CMD_READ, 4'd8, '0);
        queue_burst(CMD_READ, 4'd8, '1);
        queue_burst(CMD_READ, 4'd1, '0);
        queue_burst(CMD_WRITE, 4'd9, '1);
        queue_burst(CMD_WRITE, 4'd15, '1);
        queue_burst(CMD_READ, 4'd15, '0);
        queue_burst(CMD_UNUSED, 4'd3, 64'h0123_4567_89ab_cdef);
        queue_burst(CMD_WRITE, 4'd3, 64'ha5a5_a5a5_a5c3_b2a1);
        queue_burst(CMD_READ, 4'd0, '1);
        queue_burst(CMD_READ, 4'd2, '0);
        queue_burst(CMD_FLUSH, 4'd0, '0);
        queue_burst(CMD_READ, 4'd1, '0);
        wait_drained();

        // zero capacity: only empty bursts and flush are carried out
        write_capacity(8'd0);
        queue_burst(CMD_WRITE, 4'd0, '1);
        queue_burst(CMD_WRITE, 4'd1, '1);
        queue_burst(CMD_READ, 4'd0, '0);
        queue_burst(CMD_FLUSH, 4'd0, '0);
        wait_drained();

        // single entry: full and empty after one byte
        write_capacity(8'd1);
        queue_burst(CMD_WRITE, 4'd1, 64'h0000_0000_0000_005a);
        queue_burst(CMD_WRITE, 4'd1, 64'h0000_0000_0000_00a5);
        queue_burst(CMD_READ, 4'd1, '0);
        queue_burst(CMD_READ, 4'd1, '0);
        wait_drained();

        // five entries: no room, exact fill with wrap, reads across the wrap
        write_capacity(8'd5);
        queue_burst(CMD_WRITE, 4'd3, 64'hffff_ffff_ff33_2211);
        queue_burst(CMD_WRITE, 4'd3, 64'h0000_0000_0066_5544);
        queue_burst(CMD_WRITE, 4'd2, 64'h0000_0000_0000_5544);
        queue_burst(CMD_READ, 4'd4, '0);
        queue_burst(CMD_WRITE, 4'd4, 64'h0000_0000_8877_6655);
        queue_burst(CMD_READ, 4'd5, '0);
        wait_drained();

        // random phases, one capacity each; fill first, then drain
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_capacity(phase_caps[p]);
            send_gap_max   = (p % 3 == 0) ? 0 : 6;
            recv_stall_max = (p % 4 == 1) ? 0 : 6;
            write_hi       = (phase_caps[p] == 8'd255) ? 85 : 60;
            for (int i = 0; i < HI_ITEMS; i++)
                queue_random_burst(write_hi);
            for (int i = 0; i < LO_ITEMS; i++)
                queue_random_burst(25);
            // receiver holds off while requests keep coming
            if (p == 3 || p == 9)
                long_hold_reqs++;
            wait_drained();
        end

        $display("covered %0d requests over %0d capacity settings", replies_checked,
                 settings_used + 1);
        $display("%0d carried out, %0d refused, peak fill level %0d", replies_ok,
                 replies_refused, peak_fill);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run limit
    initial begin : run_limit
        #(TIMEOUT_NS);
        $display("timeout with %0d replies outstanding", awaited_replies.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/core/brqb_pkg.sv
rtl/core/brqb_ram.sv
rtl/core/brqb_ctrl.sv
rtl/core/byte_ring_queue_burst.sv
tb/tb_byte_ring_queue_burst.sv
